>>> rtl/core/kar_pkg.sv
package kar_pkg;

  // Default sizes of the block.
  localparam int NAV_CHANNELS_DEF = 8;
  localparam int DEBUG_KEYS_DEF   = 7;
  localparam int TIME_BITS_DEF    = 16;

  // Fixed widths of the transaction fields.
  localparam int TICK_BITS       = 16;
  localparam int NAV_PORT_BITS   = 8;
  localparam int DEBUG_PORT_BITS = 7;
  localparam int DIR_BITS        = 4;
  localparam int KIND_BITS       = 2;
  localparam int KIND_SLOTS      = 8;

  // Configuration port.
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int ACTIVE_BITS    = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_DELAY   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_CHANNELS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_KINDS   = 2'd3;

  // Register values after reset.
  localparam logic [CFG_DATA_BITS-1:0] INITIAL_DELAY_RST   = 16'd400;
  localparam logic [CFG_DATA_BITS-1:0] REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [ACTIVE_BITS-1:0]   ACTIVE_CHANNELS_RST = 4'd4;
  localparam logic [CFG_DATA_BITS-1:0] CHANNEL_KINDS_RST   = 16'hE4E4;

  // Timing settings shared by every navigation channel.
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] initial_delay;
    logic [CFG_DATA_BITS-1:0] repeat_interval;
  } timing_cfg_t;

endpackage

>>> rtl/core/kar_chan.sv
module kar_chan #(
  parameter int TIME_BITS = kar_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           held,
  input  logic [kar_pkg::TICK_BITS-1:0]  tick_ms,
  input  kar_pkg::timing_cfg_t           timing,
  output logic                           fire
);

  // Compare width covers both the timer and the 16-bit settings.
  localparam int CW = (TIME_BITS > kar_pkg::CFG_DATA_BITS) ? TIME_BITS
                                                             : kar_pkg::CFG_DATA_BITS;
  localparam logic [CW:0] TIME_MAX = ((CW + 1)'(1) << TIME_BITS) - (CW + 1)'(1);

  logic                 prev_held;
  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] last_fire;
  logic [TIME_BITS-1:0] hold_time_next;
  logic [TIME_BITS-1:0] last_fire_next;

  logic [CW:0]          sum;
  logic [TIME_BITS-1:0] sat;
  logic [TIME_BITS-1:0] since_fire;

  assign sum        = (CW + 1)'(hold_time) + (CW + 1)'(tick_ms);
  assign sat        = (sum > TIME_MAX) ? TIME_BITS'(TIME_MAX) : TIME_BITS'(sum);
  assign since_fire = sat - last_fire;

  always_comb begin
    fire           = 1'b0;
    hold_time_next = '0;
    last_fire_next = '0;
    if (held && !prev_held) begin
      fire = 1'b1;
    end else if (held) begin
      hold_time_next = sat;
      last_fire_next = last_fire;
      if ((CW'(sat) >= CW'(timing.initial_delay)) &&
          (CW'(since_fire) >= CW'(timing.repeat_interval))) begin
        fire           = 1'b1;
        last_fire_next = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held <= 1'b0;
      hold_time <= '0;
      last_fire <= '0;
    end else if (step) begin
      prev_held <= held;
      hold_time <= hold_time_next;
      last_fire <= last_fire_next;
    end
  end

endmodule

>>> rtl/core/key_auto_repeat_edge_detect.sv
// Channel   Signals                                         Direction
// --------  ----------------------------------------------  ---------
// input     in_valid, in_ready, tick_ms, nav_held,           in
//           debug_held, game_mode
// output    out_valid, out_ready, channel_fire,              out
//           nav_dir_fire, debug_press
// config    cfg_we, cfg_index, cfg_data                      in
//
// One tick transaction can be taken every cycle while in_ready is high. The input
// register feeds the result register through one saturating add, one subtract and
// two compares per channel.
// Synchronous active-high reset loads the register defaults and clears all history.
// A stalled result register still lets the input register take one more
// transaction; ready falls only when both stages are full.
module key_auto_repeat_edge_detect #(
  parameter int NAV_CHANNELS = kar_pkg::NAV_CHANNELS_DEF,
  parameter int DEBUG_KEYS   = kar_pkg::DEBUG_KEYS_DEF,
  parameter int TIME_BITS    = kar_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kar_pkg::TICK_BITS-1:0]        tick_ms,
  input  logic [kar_pkg::NAV_PORT_BITS-1:0]    nav_held,
  input  logic [kar_pkg::DEBUG_PORT_BITS-1:0]  debug_held,
  input  logic                                 game_mode,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kar_pkg::NAV_PORT_BITS-1:0]    channel_fire,
  output logic [kar_pkg::DIR_BITS-1:0]         nav_dir_fire,
  output logic [kar_pkg::DEBUG_PORT_BITS-1:0]  debug_press,

  input  logic                                 cfg_we,
  input  logic [kar_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [kar_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Config regs; the user must change them only while the block is idle; unchecked.
  logic [kar_pkg::CFG_DATA_BITS-1:0] initial_delay;
  logic [kar_pkg::CFG_DATA_BITS-1:0] repeat_interval;
  logic [kar_pkg::ACTIVE_BITS-1:0]   active_channels;
  logic [kar_pkg::CFG_DATA_BITS-1:0] channel_kinds;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay   <= kar_pkg::INITIAL_DELAY_RST;
      repeat_interval <= kar_pkg::REPEAT_INTERVAL_RST;
      active_channels <= kar_pkg::ACTIVE_CHANNELS_RST;
      channel_kinds   <= kar_pkg::CHANNEL_KINDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kar_pkg::REG_INITIAL_DELAY:   initial_delay   <= cfg_data;
        kar_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        kar_pkg::REG_ACTIVE_CHANNELS: active_channels <= cfg_data[kar_pkg::ACTIVE_BITS-1:0];
        kar_pkg::REG_CHANNEL_KINDS:   channel_kinds   <= cfg_data;
        default: ;
      endcase
    end
  end

  kar_pkg::timing_cfg_t timing;
  assign timing.initial_delay   = initial_delay;
  assign timing.repeat_interval = repeat_interval;

  // Input register. It advances into the result register whenever that one is
  // empty or being drained in the same cycle.
  logic                                s1_valid;
  logic [kar_pkg::TICK_BITS-1:0]       s1_tick;
  logic [kar_pkg::NAV_PORT_BITS-1:0]   s1_nav;
  logic [kar_pkg::DEBUG_PORT_BITS-1:0] s1_dbg;
  logic                                s1_game;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick <= tick_ms;
      s1_nav  <= nav_held;
      s1_dbg  <= debug_held;
      s1_game <= game_mode;
    end
  end

  // Navigation channels. A channel above the active count, or beyond the
  // width of nav_held, is treated as released. Channels beyond the kind
  // field are of kind up.
  logic [NAV_CHANNELS-1:0]   chan_held;
  logic [NAV_CHANNELS-1:0]   chan_fire;
  logic [kar_pkg::KIND_BITS-1:0] chan_kind [NAV_CHANNELS];

  for (genvar i = 0; i < NAV_CHANNELS; i++) begin : g_chan
    if (i < kar_pkg::NAV_PORT_BITS) begin : g_port
      assign chan_held[i] = s1_nav[i] && (32'(active_channels) > i);
    end else begin : g_none
      assign chan_held[i] = 1'b0;
    end

    if (i < kar_pkg::KIND_SLOTS) begin : g_kind
      assign chan_kind[i] = channel_kinds[kar_pkg::KIND_BITS*i +: kar_pkg::KIND_BITS];
    end else begin : g_up
      assign chan_kind[i] = '0;
    end

    kar_chan #(
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk     (clk),
      .rst     (rst),
      .step    (advance),
      .held    (chan_held[i]),
      .tick_ms (s1_tick),
      .timing  (timing),
      .fire    (chan_fire[i])
    );
  end

  // Firings are reported only in menu mode; the timers run regardless.
  logic [kar_pkg::NAV_PORT_BITS-1:0] fire_bits;
  logic [kar_pkg::DIR_BITS-1:0]      dir_bits;

  for (genvar b = 0; b < kar_pkg::NAV_PORT_BITS; b++) begin : g_fire_out
    if (b < NAV_CHANNELS) begin : g_have
      assign fire_bits[b] = chan_fire[b] && !s1_game;
    end else begin : g_zero
      assign fire_bits[b] = 1'b0;
    end
  end

  always_comb begin
    dir_bits = '0;
    for (int i = 0; i < NAV_CHANNELS; i++) begin
      if (chan_fire[i] && !s1_game) begin
        dir_bits[chan_kind[i]] = 1'b1;
      end
    end
  end

  // Debug keys. Press edges are detected only in game mode; in menu mode
  // the history is cleared so that a key still held on entry counts as new.
  logic [DEBUG_KEYS-1:0] debug_prev_held;
  logic [DEBUG_KEYS-1:0] debug_prev_held_next;
  logic [DEBUG_KEYS-1:0] dbg_now;
  logic [DEBUG_KEYS-1:0] dbg_edge;
  logic [kar_pkg::DEBUG_PORT_BITS-1:0] press_bits;

  for (genvar k = 0; k < DEBUG_KEYS; k++) begin : g_dbg
    if (k < kar_pkg::DEBUG_PORT_BITS) begin : g_port
      assign dbg_now[k] = s1_dbg[k];
    end else begin : g_none
      assign dbg_now[k] = 1'b0;
    end
  end

  assign dbg_edge             = s1_game ? (dbg_now & ~debug_prev_held) : '0;
  assign debug_prev_held_next = s1_game ? dbg_now : '0;

  for (genvar b = 0; b < kar_pkg::DEBUG_PORT_BITS; b++) begin : g_press_out
    if (b < DEBUG_KEYS) begin : g_have
      assign press_bits[b] = dbg_edge[b];
    end else begin : g_zero
      assign press_bits[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debug_prev_held <= '0;
    end else if (advance) begin
      debug_prev_held <= debug_prev_held_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      channel_fire <= fire_bits;
      nav_dir_fire <= dir_bits;
      debug_press  <= press_bits;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Sizes of the block under test and of the run.
  localparam int NAV_COUNT       = kar_pkg::NAV_CHANNELS_DEF;
  localparam int KEY_COUNT       = kar_pkg::DEBUG_KEYS_DEF;
  localparam int HOLD_MS_BITS    = kar_pkg::TIME_BITS_DEF;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TAIL_CYCLES     = 10;
  localparam int RANDOM_RUN      = 60;

  // Field widths, taken from the package.
  localparam int TICK_W = kar_pkg::TICK_BITS;
  localparam int NAV_W  = kar_pkg::NAV_PORT_BITS;
  localparam int DBG_W  = kar_pkg::DEBUG_PORT_BITS;
  localparam int DIR_W  = kar_pkg::DIR_BITS;
  localparam int KIND_W = kar_pkg::KIND_BITS;
  localparam int IDX_W  = kar_pkg::CFG_INDEX_BITS;
  localparam int CFG_W  = kar_pkg::CFG_DATA_BITS;
  localparam int ACT_W  = kar_pkg::ACTIVE_BITS;

  // One tick transaction as it enters the block, and the report it causes.
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [NAV_W-1:0]  nav;
    logic [DBG_W-1:0]  dbg;
    logic              game;
  } tick_txn_t;

  typedef struct packed {
    logic [NAV_W-1:0] fire;
    logic [DIR_W-1:0] dir;
    logic [DBG_W-1:0] press;
  } key_report_t;

  // A row of the directed table: either a register write or a tick. A tick row
  // may carry a hand-written report; otherwise the key model supplies it.
  typedef struct {
    bit               reg_write;
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] reg_value;
    tick_txn_t        txn;
    bit               typed;
    key_report_t      want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [TICK_W-1:0] tick_ms    = '0;
  logic [NAV_W-1:0]  nav_held   = '0;
  logic [DBG_W-1:0]  debug_held = '0;
  logic              game_mode  = 1'b0;

  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [NAV_W-1:0]  channel_fire;
  logic [DIR_W-1:0]  nav_dir_fire;
  logic [DBG_W-1:0]  debug_press;

  logic              cfg_we     = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]  cfg_data   = '0;

  // Copy of the register file as the key model sees it.
  logic [CFG_W-1:0] delay_setting;
  logic [CFG_W-1:0] interval_setting;
  logic [ACT_W-1:0] active_setting;
  logic [CFG_W-1:0] kinds_setting;

  // Per-channel and per-key history of the key model.
  logic                    chan_was_held [NAV_COUNT];
  logic [HOLD_MS_BITS-1:0] hold_ms       [NAV_COUNT];
  logic [HOLD_MS_BITS-1:0] last_fire_ms  [NAV_COUNT];
  logic                    key_was_held  [KEY_COUNT];

  // Reports still owed by the block, oldest first.
  key_report_t expected_reports[$];

  // The directed table, in the order it is walked.
  plan_row_t plan[$];

  // Idle rates in percent for the sender and the receiver; the main process
  // changes them per phase.
  int send_idle_pct    = 6;
  int recv_idle_pct    = 82;
  bit hold_off_request = 1'b0;
  int mismatches       = 0;
  int quiet_cycles     = 0;

  key_auto_repeat_edge_detect dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick_ms      (tick_ms),
    .nav_held     (nav_held),
    .debug_held   (debug_held),
    .game_mode    (game_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel_fire (channel_fire),
    .nav_dir_fire (nav_dir_fire),
    .debug_press  (debug_press),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Key model: advances the history by one tick and returns the report that
  // the tick should produce. Game mode keeps the channel timers running and
  // only hides the firings; outside game mode the debug key history is wiped.
  function automatic key_report_t advance_keys(tick_txn_t t);
    key_report_t             r;
    int                      used;
    logic                    held;
    logic                    fire;
    logic [HOLD_MS_BITS:0]   sum;
    r = '0;
    // Asking for more channels than exist simply means all of them.
    used = (active_setting > NAV_COUNT) ? NAV_COUNT : int'(active_setting);
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (t.game) begin
        if (t.dbg[k] && !key_was_held[k]) r.press[k] = 1'b1;
        key_was_held[k] = t.dbg[k];
      end else begin
        key_was_held[k] = 1'b0;
      end
    end
    for (int i = 0; i < NAV_COUNT; i++) begin
      // A channel beyond the active count behaves as released.
      held = (i < used) && t.nav[i];
      fire = 1'b0;
      if (held && !chan_was_held[i]) begin
        fire            = 1'b1;
        hold_ms[i]      = '0;
        last_fire_ms[i] = '0;
      end else if (held) begin
        // The hold timer sticks at its top value instead of wrapping.
        sum        = {1'b0, hold_ms[i]} + t.tick;
        hold_ms[i] = sum[HOLD_MS_BITS] ? '1 : sum[HOLD_MS_BITS-1:0];
        if (hold_ms[i] >= delay_setting &&
            hold_ms[i] - last_fire_ms[i] >= interval_setting) begin
          fire            = 1'b1;
          last_fire_ms[i] = hold_ms[i];
        end
      end else begin
        hold_ms[i]      = '0;
        last_fire_ms[i] = '0;
      end
      chan_was_held[i] = held;
      if (fire && !t.game) begin
        r.fire[i] = 1'b1;
        r.dir[kinds_setting[2*i +: KIND_W]] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t step_row(int tick, int nav, int dbg, bit game,
                                         bit typed = 1'b0, int fire = 0,
                                         int dir = 0, int press = 0);
    plan_row_t row;
    row            = '{default: '0};
    row.txn.tick   = TICK_W'(tick);
    row.txn.nav    = NAV_W'(nav);
    row.txn.dbg    = DBG_W'(dbg);
    row.txn.game   = game;
    row.typed      = typed;
    row.want.fire  = NAV_W'(fire);
    row.want.dir   = DIR_W'(dir);
    row.want.press = DBG_W'(press);
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [IDX_W-1:0] index, int value);
    plan_row_t row;
    row           = '{default: '0};
    row.reg_write = 1'b1;
    row.reg_index = index;
    row.reg_value = CFG_W'(value);
    return row;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // Offers one tick transaction, idling first at the sender's current rate.
  // At the accepting edge the key model is advanced and the report queued;
  // a hand-written report, when given, takes the place of the model's.
  task automatic send_tick(tick_txn_t t, bit typed, key_report_t want);
    key_report_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    tick_ms    <= t.tick;
    nav_held   <= t.nav;
    debug_held <= t.dbg;
    game_mode  <= t.game;
    do @(posedge clk); while (!in_ready);
    predicted = advance_keys(t);
    expected_reports.insert(expected_reports.size(), typed ? want : predicted);
  endtask

  // Stops offering and waits until every owed report has come out, then idles
  // further so that the pipeline is surely empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write through the plain write port; only called while idle.
  task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      kar_pkg::REG_INITIAL_DELAY:   delay_setting    = value;
      kar_pkg::REG_REPEAT_INTERVAL: interval_setting = value;
      kar_pkg::REG_ACTIVE_CHANNELS: active_setting   = value[ACT_W-1:0];
      kar_pkg::REG_CHANNEL_KINDS:   kinds_setting    = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. Most of it is runs of ticks in which a key pattern stays
  // held, with small elapsed times so that the hold timers cross the delay and
  // repeat; debug keys change a bit at a time. The rest is plain noise.
  task automatic run_random(int count);
    tick_txn_t        t;
    logic [NAV_W-1:0] pattern;
    logic [DBG_W-1:0] debug_keys;
    bit               in_game;
    int               sent;
    int               run_len;
    int               pick;
    sent       = 0;
    debug_keys = '0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        t = tick_txn_t'($urandom);
        send_tick(t, 1'b0, '0);
        sent++;
      end else begin
        pattern = NAV_W'($urandom_range(0, 255));
        in_game = ($urandom_range(0, 99) < 30);
        run_len = $urandom_range(3, 20);
        for (int n = 0; n < run_len; n++) begin
          if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, KEY_COUNT - 1);
            debug_keys[pick] = ~debug_keys[pick];
          end
          // Now and then a huge step drives the timers into saturation.
          if ($urandom_range(0, 39) == 0) t.tick = TICK_W'($urandom);
          else t.tick = TICK_W'($urandom_range(0, 160));
          t.nav = pattern;
          if ($urandom_range(0, 9) == 0) begin
            pick = $urandom_range(0, NAV_COUNT - 1);
            t.nav[pick] = ~t.nav[pick];
          end
          t.dbg  = debug_keys;
          t.game = in_game;
          send_tick(t, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Receiver: ready at random, except for one long hold-off requested by the
  // main process. The hold-off is counted here so that the sender keeps
  // offering transactions and the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checking and the watchdog. Both sample at the clock edge, before
  // any register in the block or the testbench has moved.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with none expected, actual fire 0x%0h dir 0x%0h press 0x%0h",
                   $time, channel_fire, nav_dir_fire, debug_press);
          mismatches++;
        end else begin
          compare_field("channel_fire", 8'(expected_reports[0].fire), 8'(channel_fire));
          compare_field("nav_dir_fire", 8'(expected_reports[0].dir), 8'(nav_dir_fire));
          compare_field("debug_press", 8'(expected_reports[0].press), 8'(debug_press));
          void'(expected_reports.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    delay_setting    = kar_pkg::INITIAL_DELAY_RST;
    interval_setting = kar_pkg::REPEAT_INTERVAL_RST;
    active_setting   = kar_pkg::ACTIVE_CHANNELS_RST;
    kinds_setting    = kar_pkg::CHANNEL_KINDS_RST;
    foreach (chan_was_held[i]) begin
      chan_was_held[i] = 1'b0;
      hold_ms[i]       = '0;
      last_fire_ms[i]  = '0;
    end
    foreach (key_was_held[k]) key_was_held[k] = 1'b0;

    // Directed table. With the reset registers channels 0..3 are up, down,
    // left and right, the delay is 400 ms and the repeat interval 100 ms.
    add_row(step_row(0, 8'h00, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    // Press edges on all active channels; debug keys are ignored in menu mode.
    add_row(step_row(10, 8'h0F, 7'h7F, 0, 1, 8'h0F, 4'hF, 7'h00));
    // One millisecond short of the delay, then exactly at it.
    add_row(step_row(399, 8'h0F, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    add_row(step_row(1, 8'h0F, 7'h00, 0, 1, 8'h0F, 4'hF, 7'h00));
    // Channel 0 alone: one short of the interval, then exactly at it.
    add_row(step_row(99, 8'h01, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    add_row(step_row(1, 8'h01, 7'h00, 0, 1, 8'h01, 4'h1, 7'h00));
    // The timer saturates; once it has fired there, it cannot fire again.
    add_row(step_row(16'hFFFF, 8'h01, 7'h00, 0, 1, 8'h01, 4'h1, 7'h00));
    add_row(step_row(16'hFFFF, 8'h01, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    // Channels above the active count never fire.
    add_row(step_row(5, 8'hFF, 7'h00, 0, 1, 8'h0E, 4'hE, 7'h00));
    // Game mode: debug press edges are reported and channel firings hidden.
    add_row(step_row(5, 8'h00, 7'h55, 1, 1, 8'h00, 4'h0, 7'h55));
    add_row(step_row(5, 8'h0F, 7'h7F, 1, 1, 8'h00, 4'h0, 7'h2A));
    add_row(step_row(400, 8'h0F, 7'h7F, 1, 1, 8'h00, 4'h0, 7'h00));
    // Back in menu mode the timers have kept running through game mode.
    add_row(step_row(100, 8'h0F, 7'h7F, 0));
    // Menu mode wiped the debug history, so every held key is a new press.
    add_row(step_row(0, 8'h00, 7'h7F, 1, 1, 8'h00, 4'h0, 7'h7F));
    add_row(step_row(0, 8'h00, 7'h00, 1));
    // Too many channels means all eight; every channel of kind up.
    add_row(reg_row(kar_pkg::REG_ACTIVE_CHANNELS, 15));
    add_row(reg_row(kar_pkg::REG_CHANNEL_KINDS, 16'h0000));
    add_row(step_row(0, 8'hFF, 7'h00, 0, 1, 8'hFF, 4'h1, 7'h00));
    // Zero delay and zero interval: a held channel fires on every tick.
    add_row(reg_row(kar_pkg::REG_INITIAL_DELAY, 0));
    add_row(reg_row(kar_pkg::REG_REPEAT_INTERVAL, 0));
    add_row(step_row(0, 8'hFF, 7'h00, 0, 1, 8'hFF, 4'h1, 7'h00));
    add_row(step_row(7, 8'hFF, 7'h00, 0, 1, 8'hFF, 4'h1, 7'h00));
    // Largest delay and interval, every channel of kind right.
    add_row(reg_row(kar_pkg::REG_INITIAL_DELAY, 16'hFFFF));
    add_row(reg_row(kar_pkg::REG_REPEAT_INTERVAL, 16'hFFFF));
    add_row(reg_row(kar_pkg::REG_CHANNEL_KINDS, 16'hFFFF));
    add_row(step_row(0, 8'h00, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    add_row(step_row(0, 8'hFF, 7'h00, 0, 1, 8'hFF, 4'h8, 7'h00));
    add_row(step_row(16'hFFFF, 8'hFF, 7'h00, 0, 1, 8'hFF, 4'h8, 7'h00));
    add_row(step_row(1, 8'hFF, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));
    // No active channels at all.
    add_row(reg_row(kar_pkg::REG_ACTIVE_CHANNELS, 0));
    add_row(step_row(3, 8'hFF, 7'h00, 0, 1, 8'h00, 4'h0, 7'h00));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].reg_write) begin
        settle();
        write_reg(plan[n].reg_index, plan[n].reg_value);
      end else begin
        send_tick(plan[n].txn, plan[n].typed, plan[n].want);
      end
    end

    // Three random phases: a slow receiver, then a slow sender, then neither
    // idles. Each phase starts from fresh register settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 6 : 0;
      settle();
      write_reg(kar_pkg::REG_INITIAL_DELAY, CFG_W'($urandom_range(0, 600)));
      write_reg(kar_pkg::REG_REPEAT_INTERVAL, CFG_W'($urandom_range(0, 200)));
      write_reg(kar_pkg::REG_ACTIVE_CHANNELS,
                CFG_W'((phase == 2) ? NAV_COUNT : $urandom_range(1, 15)));
      write_reg(kar_pkg::REG_CHANNEL_KINDS, CFG_W'($urandom_range(0, 16'hFFFF)));
      run_random(RANDOM_RUN);
      // The receiver stops for a long stretch while the sender keeps going.
      if (phase == 0) hold_off_request = 1'b1;
      // The sender pauses until every owed report has been delivered.
      if (phase == 1) settle();
      run_random(RANDOM_RUN);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
